// ===== rtl/core/wpp_pkg.sv =====
// shared types, constants and helpers for the wav pcm stream parser
`default_nettype none
package wpp_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_RIFF  = 2'd1,
    STATUS_BAD_DATA  = 2'd2,
    STATUS_BAD_DEPTH = 2'd3
  } status_e;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  // header byte positions
  localparam logic [5:0] HdrLen       = 6'd44;
  localparam logic [5:0] PosRiffLast  = 6'd3;
  localparam logic [5:0] PosChanFirst = 6'd22;
  localparam logic [5:0] PosChanLast  = 6'd23;
  localparam logic [5:0] PosRateFirst = 6'd24;
  localparam logic [5:0] PosRateLast  = 6'd27;
  localparam logic [5:0] PosBitsFirst = 6'd34;
  localparam logic [5:0] PosBitsLast  = 6'd35;
  localparam logic [5:0] PosDataFirst = 6'd36;
  localparam logic [5:0] PosDataLast  = 6'd39;
  localparam logic [5:0] PosLenFirst  = 6'd40;
  localparam logic [5:0] PosLenLast   = 6'd43;

  localparam logic [15:0] Depth8     = 16'd8;
  localparam logic [15:0] Depth16    = 16'd16;
  localparam logic [15:0] StereoChan = 16'd2;
  localparam logic [7:0]  SignFlip   = 8'h80;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic signed [15:0] sample_value;
    logic               channel_index;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate_hz;
    logic [15:0]        sample_bits;
    logic [31:0]        payload_length;
    logic               last_sample;
  } rec_t;

  function automatic logic [7:0] riff_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = 8'h52;
      2'd1: c = 8'h49;
      2'd2: c = 8'h46;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] data_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = 8'h64;
      2'd1: c = 8'h61;
      2'd2: c = 8'h74;
      default: c = 8'h61;
    endcase
    return c;
  endfunction

  // tag errors win over a bad bit depth
  function automatic status_e hdr_status(input status_e tag, input logic [15:0] bits);
    status_e s;
    if (tag != STATUS_OK) begin
      s = tag;
    end else if (bits != Depth8 && bits != Depth16) begin
      s = STATUS_BAD_DEPTH;
    end else begin
      s = STATUS_OK;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wav_pcm_stream_parser_core.sv =====
// top level of the wav pcm stream parser
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | file_byte_i, file_start_i
//   out     | output    | out_valid_o / out_stall_i| kind, status, sample, header fields
//
// one byte is taken every clock while the result queue has room; the front end
// finishes each byte in the cycle it is accepted
// a result leaves through the queue storage and then the output register after its byte
// the two-entry queue lets the byte side run on while a word waits at the output
// rst_ni clears the parse state, queue and output valid asynchronously
`default_nettype none
module wav_pcm_stream_parser_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         file_byte_i,
  input  wire logic               file_start_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    kind_o,
  output logic [1:0]              status_o,
  output logic signed [15:0]      sample_value_o,
  output logic                    channel_index_o,
  output logic [15:0]             channel_count_o,
  output logic [31:0]             sample_rate_hz_o,
  output logic [15:0]             sample_bits_o,
  output logic [31:0]             payload_length_o,
  output logic                    last_sample_o
);

  logic          push, pop, q_empty, q_full;
  wpp_pkg::rec_t front_rec, q_rec, out_rec;

  wpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .file_byte_i  (file_byte_i),
    .file_start_i (file_start_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .rec_o        (front_rec)
  );

  wpp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .pop_i   (pop),
    .rec_o   (q_rec),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  wpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_rec_i     (q_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rec_o       (out_rec)
  );

  assign kind_o           = out_rec.kind;
  assign status_o         = out_rec.status;
  assign sample_value_o   = out_rec.sample_value;
  assign channel_index_o  = out_rec.channel_index;
  assign channel_count_o  = out_rec.channel_count;
  assign sample_rate_hz_o = out_rec.sample_rate_hz;
  assign sample_bits_o    = out_rec.sample_bits;
  assign payload_length_o = out_rec.payload_length;
  assign last_sample_o    = out_rec.last_sample;

endmodule
`default_nettype wire

// ===== rtl/core/wpp_front.sv =====
// front end: takes file bytes, parses the header and forms result records
`default_nettype none
module wpp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    file_byte_i,
  input  wire logic          file_start_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output wpp_pkg::rec_t      rec_o
);

  logic                 acc;
  logic [5:0]           pos_q, pos_d, pos_e;
  wpp_pkg::status_e     tag_q, tag_d, tag_e;
  logic [15:0]          chan_q, chan_d, chan_e;
  logic [31:0]          rate_q, rate_d, rate_e;
  logic [15:0]          bits_q, bits_d, bits_e;
  logic [31:0]          len_q, len_d, len_e;
  logic [31:0]          cnt_q, cnt_d, cnt_e;
  logic [7:0]           hold_q, hold_d, hold_e;
  logic                 phase_q, phase_d, phase_e;
  logic                 tog_q, tog_d, tog_e;
  logic [5:0]           off;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i & ~q_full_i;

  // a start flag sees the file state as freshly cleared
  always_comb begin
    if (file_start_i) begin
      pos_e   = '0;
      tag_e   = wpp_pkg::STATUS_OK;
      chan_e  = '0;
      rate_e  = '0;
      bits_e  = '0;
      len_e   = '0;
      cnt_e   = '0;
      hold_e  = '0;
      phase_e = 1'b0;
      tog_e   = 1'b0;
    end else begin
      pos_e   = pos_q;
      tag_e   = tag_q;
      chan_e  = chan_q;
      rate_e  = rate_q;
      bits_e  = bits_q;
      len_e   = len_q;
      cnt_e   = cnt_q;
      hold_e  = hold_q;
      phase_e = phase_q;
      tog_e   = tog_q;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    tag_d   = tag_q;
    chan_d  = chan_q;
    rate_d  = rate_q;
    bits_d  = bits_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    hold_d  = hold_q;
    phase_d = phase_q;
    tog_d   = tog_q;
    push_o  = 1'b0;
    off     = '0;
    rec_o   = '0;
    if (acc) begin
      pos_d   = pos_e;
      tag_d   = tag_e;
      chan_d  = chan_e;
      rate_d  = rate_e;
      bits_d  = bits_e;
      len_d   = len_e;
      cnt_d   = cnt_e;
      hold_d  = hold_e;
      phase_d = phase_e;
      tog_d   = tog_e;
      if (pos_e < wpp_pkg::HdrLen) begin
        if (pos_e <= wpp_pkg::PosRiffLast) begin
          if (file_byte_i != wpp_pkg::riff_char(pos_e[1:0]) && tag_e == wpp_pkg::STATUS_OK)
            tag_d = wpp_pkg::STATUS_BAD_RIFF;
        end else if (pos_e >= wpp_pkg::PosDataFirst && pos_e <= wpp_pkg::PosDataLast) begin
          off = pos_e - wpp_pkg::PosDataFirst;
          if (file_byte_i != wpp_pkg::data_char(off[1:0]) && tag_e == wpp_pkg::STATUS_OK)
            tag_d = wpp_pkg::STATUS_BAD_DATA;
        end else if (pos_e >= wpp_pkg::PosChanFirst && pos_e <= wpp_pkg::PosChanLast) begin
          off = pos_e - wpp_pkg::PosChanFirst;
          chan_d[{off[0], 3'b000} +: 8] = file_byte_i;
        end else if (pos_e >= wpp_pkg::PosRateFirst && pos_e <= wpp_pkg::PosRateLast) begin
          off = pos_e - wpp_pkg::PosRateFirst;
          rate_d[{off[1:0], 3'b000} +: 8] = file_byte_i;
        end else if (pos_e >= wpp_pkg::PosBitsFirst && pos_e <= wpp_pkg::PosBitsLast) begin
          off = pos_e - wpp_pkg::PosBitsFirst;
          bits_d[{off[0], 3'b000} +: 8] = file_byte_i;
        end else if (pos_e >= wpp_pkg::PosLenFirst && pos_e <= wpp_pkg::PosLenLast) begin
          off = pos_e - wpp_pkg::PosLenFirst;
          len_d[{off[1:0], 3'b000} +: 8] = file_byte_i;
        end
        pos_d = pos_e + 6'd1;
        if (pos_e == wpp_pkg::PosLenLast) begin
          cnt_d        = '0;
          phase_d      = 1'b0;
          tog_d        = 1'b0;
          hold_d       = '0;
          push_o       = 1'b1;
          rec_o.kind   = wpp_pkg::KIND_HEADER;
          rec_o.status = wpp_pkg::hdr_status(tag_d, bits_d);
        end
      end else if (wpp_pkg::hdr_status(tag_e, bits_e) == wpp_pkg::STATUS_OK &&
                   cnt_e < len_e) begin
        cnt_d = cnt_e + 32'd1;
        if (bits_e == wpp_pkg::Depth8) begin
          push_o             = 1'b1;
          rec_o.kind         = wpp_pkg::KIND_SAMPLE;
          rec_o.sample_value = $signed({file_byte_i ^ wpp_pkg::SignFlip, 8'h00});
          rec_o.last_sample  = (cnt_d == len_e);
        end else if (!phase_e) begin
          hold_d  = file_byte_i;
          phase_d = 1'b1;
        end else begin
          phase_d             = 1'b0;
          push_o              = 1'b1;
          rec_o.kind          = wpp_pkg::KIND_SAMPLE;
          rec_o.sample_value  = $signed({file_byte_i, hold_e});
          rec_o.channel_index = tog_e;
          rec_o.last_sample   = (cnt_d == len_e);
          tog_d = (chan_e == wpp_pkg::StereoChan) ? ~tog_e : 1'b0;
        end
      end
      rec_o.channel_count  = chan_d;
      rec_o.sample_rate_hz = rate_d;
      rec_o.sample_bits    = bits_d;
      rec_o.payload_length = len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      tag_q   <= wpp_pkg::STATUS_OK;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      hold_q  <= '0;
      phase_q <= 1'b0;
      tog_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      tag_q   <= tag_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      hold_q  <= hold_d;
      phase_q <= phase_d;
      tog_q   <= tog_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wpp_queue.sv =====
// short result queue between the front end and the output stage
`default_nettype none
module wpp_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire wpp_pkg::rec_t rec_i,
  input  wire logic          pop_i,
  output wpp_pkg::rec_t      rec_o,
  output logic               empty_o,
  output logic               full_o
);

  wpp_pkg::rec_t                  store_q [wpp_pkg::QueueDepth];
  logic [wpp_pkg::QueuePtrW-1:0]  wr_q, rd_q;
  logic [wpp_pkg::QueueCntW-1:0]  cnt_q;
  logic                           do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == wpp_pkg::QueueCntW'(wpp_pkg::QueueDepth));
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rec_o   = store_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) store_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == wpp_pkg::QueuePtrW'(wpp_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == wpp_pkg::QueuePtrW'(wpp_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wpp_back.sv =====
// back end: output register fed from the queue
`default_nettype none
module wpp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire wpp_pkg::rec_t q_rec_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output wpp_pkg::rec_t      rec_o
);

  logic          valid_q;
  wpp_pkg::rec_t rec_q;

  // refill when the register is empty or its word leaves this cycle
  assign pop_o       = ~q_empty_i & (~valid_q | ~out_stall_i);
  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= q_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wpp_checker.sv =====
// port-level checks for the wav pcm stream parser, bound to the top level
`default_nettype none
module wpp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic               kind_o,
  input wire logic [1:0]         status_o,
  input wire logic signed [15:0] sample_value_o,
  input wire logic               channel_index_o,
  input wire logic [15:0]        channel_count_o,
  input wire logic [15:0]        sample_bits_o,
  input wire logic               last_sample_o
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_value_o) &&
    $stable(kind_o) && $stable(last_sample_o))
    else $error("output word changed while stalled");

  // samples only follow a clean header
  a_sample_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == wpp_pkg::KIND_SAMPLE |->
    status_o == wpp_pkg::STATUS_OK &&
    (sample_bits_o == wpp_pkg::Depth8 || sample_bits_o == wpp_pkg::Depth16))
    else $error("sample word after a bad header");

  a_header_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == wpp_pkg::KIND_HEADER |->
    sample_value_o == '0 && !last_sample_o && !channel_index_o)
    else $error("header word carries sample fields");

  // second channel only for 16-bit stereo
  a_right_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && channel_index_o |->
    channel_count_o == wpp_pkg::StereoChan && sample_bits_o == wpp_pkg::Depth16)
    else $error("channel one outside 16-bit stereo");

endmodule

bind wav_pcm_stream_parser_core wpp_checker u_wpp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .kind_o          (kind_o),
  .status_o        (status_o),
  .sample_value_o  (sample_value_o),
  .channel_index_o (channel_index_o),
  .channel_count_o (channel_count_o),
  .sample_bits_o   (sample_bits_o),
  .last_sample_o   (last_sample_o)
);
`default_nettype wire
